// ===== design/fcpm_pkg.sv =====
// Shared widths, codes and status types of the false-color palette mapper.
package fcpm_pkg;

   // Field and register widths fixed by the interface.
   localparam int CFG_W       = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int POS_W       = 9;
   localparam int COMP_W      = 8;
   localparam int COLOR_W     = 24;

   // Ramp arithmetic: components held in unsigned 8.12 fixed point.
   localparam int RAMP_FRAC = 12;
   localparam int RAMP_Q_W  = 20;
   localparam int ACC_W     = 22;

   // Command codes of an input transaction.
   localparam logic CMD_POINT  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_MIN     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_SPAN    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_VALUE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_COLOR = 2'd3;

   // Configuration reset values.
   localparam logic [CFG_W-1:0]   RANGE_MIN_RESET     = 32'd0;
   localparam logic [CFG_W-1:0]   RANGE_SPAN_RESET    = 32'd1;
   localparam logic [CFG_W-1:0]   DEFAULT_VALUE_RESET = 32'd0;
   localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RESET = 24'hFF00FF;

   // Status of the ramp engine toward the top level.
   typedef struct packed {
      logic wr_en;
      logic done;
   } ramp_status_type;

   // Status of the index unit toward the top level.
   typedef struct packed {
      logic done;
      logic is_default;
   } index_status_type;

endpackage

// ===== design/fcpm_div.sv =====
// Iterative restoring divider that produces one quotient bit per cycle.
module fcpm_div #(
   parameter int DVW = 32,
   parameter int QW  = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW+QW-1:0] dividend,
   input  logic [DVW-1:0] divisor,
   output logic [QW-1:0]  quotient,
   output logic           done
);

   localparam int RW = DVW + QW;
   localparam int CW = $clog2(QW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] dsh_ff, dsh_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic          fits;

   // The caller guarantees that the quotient fits in QW bits.
   assign fits = (rem_ff >= dsh_ff);

   // One trial subtraction per cycle, divisor shifted right each step.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QW);
         rem_in  = dividend;
         dsh_in  = RW'(divisor) << (QW - 1);
         quo_in  = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[QW-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== design/fcpm_ramp.sv =====
// Ramp engine: computes per-component slopes and streams the ramp entries.
module fcpm_ramp #(
   parameter int ENTRIES = 256,
   localparam int PW = $clog2(ENTRIES + 1),
   localparam int IW = $clog2(ENTRIES)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [PW-1:0]                bottom,
   input  logic [PW-1:0]                top,
   input  logic [fcpm_pkg::COLOR_W-1:0] color_lo,
   input  logic [fcpm_pkg::COLOR_W-1:0] color_hi,
   output fcpm_pkg::ramp_status_type    status,
   output logic [IW-1:0]                wr_addr,
   output logic [fcpm_pkg::COLOR_W-1:0] wr_data
);

   localparam int DW = PW + fcpm_pkg::RAMP_Q_W;
   localparam int AW = fcpm_pkg::ACC_W;
   localparam int CPW = fcpm_pkg::COMP_W;
   localparam int FR = fcpm_pkg::RAMP_FRAC;

   localparam logic [1:0] RS_IDLE  = 2'd0;
   localparam logic [1:0] RS_DIV   = 2'd1;
   localparam logic [1:0] RS_WRITE = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [PW-1:0] j_ff, j_in;
   logic [PW-1:0] last_ff, last_in;
   logic          neg_ff [3];
   logic          neg_in [3];
   logic signed [AW-1:0] acc_ff [3];
   logic signed [AW-1:0] acc_in [3];
   logic signed [AW-1:0] delta_ff [3];
   logic signed [AW-1:0] delta_in [3];
   logic signed [AW-1:0] acc_sum [3];
   logic [fcpm_pkg::RAMP_Q_W-1:0] quo [3];
   logic          div_done [3];
   logic [DW-1:0] dividend [3];
   logic [CPW-1:0] lo_c [3];
   logic [CPW-1:0] hi_c [3];
   logic [CPW-1:0] mag_c [3];
   logic [CPW-1:0] sat_c [3];
   logic [PW-1:0] span_n;
   logic          lanes_done;
   logic          wr_en;
   logic          done;

   // An accumulator below zero reads as 0, one past 8.12 range as full scale.
   function automatic logic [CPW-1:0] ramp_sat(input logic signed [AW-1:0] acc);
      if (acc[AW-1]) begin
         return '0;
      end else if (|acc[AW-2:FR+CPW]) begin
         return '1;
      end else begin
         return acc[FR+CPW-1:FR];
      end
   endfunction

   assign span_n = top - bottom;

   // One lane per color component; red sits in the top byte.
   for (genvar k = 0; k < 3; k++) begin : g_lane
      assign lo_c[k]  = color_lo[fcpm_pkg::COLOR_W-CPW*(k+1) +: CPW];
      assign hi_c[k]  = color_hi[fcpm_pkg::COLOR_W-CPW*(k+1) +: CPW];
      assign mag_c[k] = (hi_c[k] >= lo_c[k]) ? (hi_c[k] - lo_c[k]) : (lo_c[k] - hi_c[k]);
      assign dividend[k] = DW'({mag_c[k], {FR{1'b0}}});

      fcpm_div #(
         .DVW (PW),
         .QW  (fcpm_pkg::RAMP_Q_W)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (start),
         .dividend (dividend[k]),
         .divisor  (span_n),
         .quotient (quo[k]),
         .done     (div_done[k])
      );

      assign acc_sum[k] = acc_ff[k] + delta_ff[k];
      assign sat_c[k]   = ramp_sat(acc_sum[k]);
   end

   assign lanes_done = div_done[0] & div_done[1] & div_done[2];

   // Sequencer: slope division, then one palette entry per cycle.
   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      last_in  = last_ff;
      wr_en    = 1'b0;
      done     = 1'b0;
      for (int k = 0; k < 3; k++) begin
         neg_in[k]   = neg_ff[k];
         acc_in[k]   = acc_ff[k];
         delta_in[k] = delta_ff[k];
      end
      unique case (state_ff)
         RS_IDLE: begin
            if (start) begin
               state_in = RS_DIV;
               j_in     = bottom + 1'b1;
               last_in  = top - 1'b1;
               for (int k = 0; k < 3; k++) begin
                  neg_in[k] = (hi_c[k] < lo_c[k]);
                  acc_in[k] = AW'({lo_c[k], {FR{1'b0}}});
               end
            end
         end
         RS_DIV: begin
            if (lanes_done) begin
               state_in = RS_WRITE;
               for (int k = 0; k < 3; k++) begin
                  delta_in[k] = neg_ff[k] ? -AW'(quo[k]) : AW'(quo[k]);
               end
            end
         end
         RS_WRITE: begin
            wr_en = 1'b1;
            j_in  = j_ff + 1'b1;
            for (int k = 0; k < 3; k++) begin
               acc_in[k] = acc_sum[k];
            end
            if (j_ff == last_ff) begin
               done     = 1'b1;
               state_in = RS_IDLE;
            end
         end
         default: begin
            state_in = RS_IDLE;
         end
      endcase
   end

   // Control register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      last_ff <= last_in;
      for (int k = 0; k < 3; k++) begin
         neg_ff[k]   <= neg_in[k];
         acc_ff[k]   <= acc_in[k];
         delta_ff[k] <= delta_in[k];
      end
   end

   assign status.wr_en = wr_en;
   assign status.done  = done;
   assign wr_addr      = j_ff[IW-1:0];
   assign wr_data      = {sat_c[0], sat_c[1], sat_c[2]};

endmodule

// ===== design/fcpm_index.sv =====
// Index unit: normalizes a sample against the range and finds its palette entry.
module fcpm_index #(
   parameter int ENTRIES     = 256,
   parameter int SAMPLE_BITS = 32,
   localparam int IW = $clog2(ENTRIES)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [SAMPLE_BITS-1:0]     sample,
   input  logic signed [fcpm_pkg::CFG_W-1:0] range_min,
   input  logic [fcpm_pkg::CFG_W-1:0]        range_span,
   input  logic signed [fcpm_pkg::CFG_W-1:0] default_value,
   output fcpm_pkg::index_status_type        status,
   output logic [IW-1:0]                     index
);

   localparam int CW  = fcpm_pkg::CFG_W;
   localparam int XW  = ((SAMPLE_BITS > CW) ? SAMPLE_BITS : CW) + 1;
   localparam int PRW = CW + IW;

   localparam logic [1:0] IX_IDLE   = 2'd0;
   localparam logic [1:0] IX_CHECK  = 2'd1;
   localparam logic [1:0] IX_DECIDE = 2'd2;
   localparam logic [1:0] IX_DIV    = 2'd3;

   logic [1:0]     phase_ff, phase_in;
   logic           done_ff, done_in;
   logic           def_ff, def_in;
   logic           neg_ff, neg_in;
   logic           over_ff, over_in;
   logic [XW-1:0]  d_ff, d_in;
   logic [PRW-1:0] prod_ff, prod_in;
   logic [IW-1:0]  index_ff, index_in;
   logic signed [XW-1:0] vx;
   logic signed [XW-1:0] mnx;
   logic signed [XW-1:0] dvx;
   logic [CW-1:0]  span_eff;
   logic           div_start;
   logic           div_done;
   logic [IW-1:0]  div_quo;

   // Sign-extend everything to a common width so the difference cannot wrap.
   assign vx       = XW'(sample);
   assign mnx      = XW'(range_min);
   assign dvx      = XW'(default_value);
   assign span_eff = (range_span == '0) ? CW'(1) : range_span;

   // Subtract, then classify and scale, then divide only for in-range samples.
   always_comb begin
      phase_in  = phase_ff;
      done_in   = 1'b0;
      def_in    = def_ff;
      neg_in    = neg_ff;
      over_in   = over_ff;
      d_in      = d_ff;
      prod_in   = prod_ff;
      index_in  = index_ff;
      div_start = 1'b0;
      unique case (phase_ff)
         IX_IDLE: begin
            if (start) begin
               phase_in = IX_CHECK;
               d_in     = vx - mnx;
               def_in   = (vx == dvx);
            end
         end
         IX_CHECK: begin
            phase_in = IX_DECIDE;
            neg_in   = d_ff[XW-1];
            over_in  = (d_ff >= XW'(span_eff));
            prod_in  = PRW'(d_ff[CW-1:0]) * PRW'(ENTRIES - 1);
         end
         IX_DECIDE: begin
            if (def_ff || neg_ff) begin
               index_in = '0;
               done_in  = 1'b1;
               phase_in = IX_IDLE;
            end else if (over_ff) begin
               index_in = IW'(ENTRIES - 1);
               done_in  = 1'b1;
               phase_in = IX_IDLE;
            end else begin
               div_start = 1'b1;
               phase_in  = IX_DIV;
            end
         end
         IX_DIV: begin
            if (div_done) begin
               index_in = div_quo;
               done_in  = 1'b1;
               phase_in = IX_IDLE;
            end
         end
      endcase
   end

   // The offset is below the span here, so the quotient stays below ENTRIES.
   fcpm_div #(
      .DVW (CW),
      .QW  (IW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (span_eff),
      .quotient (div_quo),
      .done     (div_done)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= IX_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      def_ff   <= def_in;
      neg_ff   <= neg_in;
      over_ff  <= over_in;
      d_ff     <= d_in;
      prod_ff  <= prod_in;
      index_ff <= index_in;
   end

   assign status.done       = done_ff;
   assign status.is_default = def_ff;
   assign index             = index_ff;

endmodule

// ===== design/false_color_palette_mapper_top.sv =====
// Top level of the false-color palette mapper: palette memory, sequencing and ports.
//
// Usage: each request transaction either loads a palette control point
// (req_cmd low) or maps one sample (req_cmd high). A control point writes its
// own entry and, unless it starts a new palette, a linear ramp from the last
// point. A mapped sample returns one response transaction with its color and
// a flag telling whether it matched the no-data value. Points return nothing.
// Configuration registers must be written through the csr_ channel only while
// idle; the block itself does not enforce this. Items are handled one at a
// time; req_stall is high while one is in work. A point without a ramp is
// written in the cycle it is accepted. A point with a ramp is handled by the
// 20-step slope divider, then one memory write per entry. A sample goes
// through the bit-serial index divider and the memory read to its response;
// no-data and out-of-range samples skip the divider. The next item is taken
// in the cycle after the previous one finishes.
// After reset the palette is cleared to zero, one entry per cycle, with
// req_stall high until every entry is written. A response waits in the output
// register while rsp_stall is high; the block stalls only if a second result
// is ready before the first one is taken.
module false_color_palette_mapper_top #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int SAMPLE_BITS     = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic                                 req_first_point,
   input  logic [fcpm_pkg::POS_W-1:0]           req_point_position,
   input  logic [fcpm_pkg::COMP_W-1:0]          req_point_red,
   input  logic [fcpm_pkg::COMP_W-1:0]          req_point_green,
   input  logic [fcpm_pkg::COMP_W-1:0]          req_point_blue,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [fcpm_pkg::COMP_W-1:0]          rsp_red,
   output logic [fcpm_pkg::COMP_W-1:0]          rsp_green,
   output logic [fcpm_pkg::COMP_W-1:0]          rsp_blue,
   output logic                                 rsp_was_default,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fcpm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fcpm_pkg::CFG_W-1:0]           csr_data
);

   localparam int IW   = $clog2(PALETTE_ENTRIES);
   localparam int PW   = $clog2(PALETTE_ENTRIES + 1);
   localparam int CMPW = (PW > fcpm_pkg::POS_W) ? PW : fcpm_pkg::POS_W;
   localparam int CLW  = fcpm_pkg::COLOR_W;
   localparam int CPW  = fcpm_pkg::COMP_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RAMP  = 3'd2;
   localparam logic [2:0] ST_INDEX = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [IW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [PW-1:0]  last_pos_ff, last_pos_in;
   logic [CLW-1:0] last_color_ff, last_color_in;
   logic           have_last_ff, have_last_in;
   logic signed [fcpm_pkg::CFG_W-1:0] range_min_ff, range_min_in;
   logic [fcpm_pkg::CFG_W-1:0]        range_span_ff, range_span_in;
   logic signed [fcpm_pkg::CFG_W-1:0] default_value_ff, default_value_in;
   logic [CLW-1:0] default_color_ff, default_color_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [CLW-1:0] rsp_color_ff, rsp_color_in;
   logic           rsp_default_ff, rsp_default_in;

   // Palette memory and its registered read data.
   logic [CLW-1:0] palette_mem [PALETTE_ENTRIES];
   logic [CLW-1:0] rdata_ff;
   logic           mem_we;
   logic [IW-1:0]  mem_waddr;
   logic [CLW-1:0] mem_wdata;
   logic           mem_re;
   logic [IW-1:0]  mem_raddr;

   logic           req_accept;
   logic           csr_write;
   logic           out_load;
   logic [CMPW-1:0] pos_ext;
   logic [PW-1:0]  pos_clamp;
   logic           pos_in_range;
   logic           ramp_needed;
   logic [CLW-1:0] point_color;
   logic           ramp_start;
   logic           idx_start;

   fcpm_pkg::ramp_status_type  ramp_st;
   fcpm_pkg::index_status_type idx_st;
   logic [IW-1:0]  ramp_addr;
   logic [CLW-1:0] ramp_data;
   logic [IW-1:0]  idx_index;

   // Handshakes.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   // Control point decode: clamp the position to the end of the palette.
   assign pos_ext      = CMPW'(req_point_position);
   assign pos_clamp    = (pos_ext > CMPW'(PALETTE_ENTRIES)) ? PW'(PALETTE_ENTRIES)
                                                            : pos_ext[PW-1:0];
   assign pos_in_range = (pos_clamp < PW'(PALETTE_ENTRIES));
   assign point_color  = {req_point_red, req_point_green, req_point_blue};
   assign ramp_needed  = !req_first_point && have_last_ff &&
                         ((PW+1)'(pos_clamp) > ((PW+1)'(last_pos_ff) + 1'b1));

   // Main sequencer: clearing pass, point writes, ramps and sample lookups.
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      last_pos_in   = last_pos_ff;
      last_color_in = last_color_ff;
      have_last_in  = have_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = clr_cnt_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = idx_index;
      ramp_start    = 1'b0;
      idx_start     = 1'b0;
      out_load      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == IW'(PALETTE_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_cmd == fcpm_pkg::CMD_POINT) begin
                  if (pos_in_range) begin
                     mem_we    = 1'b1;
                     mem_waddr = pos_clamp[IW-1:0];
                     mem_wdata = point_color;
                  end
                  last_pos_in   = pos_clamp;
                  last_color_in = point_color;
                  have_last_in  = 1'b1;
                  if (ramp_needed) begin
                     ramp_start = 1'b1;
                     state_in   = ST_RAMP;
                  end
               end else begin
                  idx_start = 1'b1;
                  state_in  = ST_INDEX;
               end
            end
         end
         ST_RAMP: begin
            mem_we    = ramp_st.wr_en;
            mem_waddr = ramp_addr;
            mem_wdata = ramp_data;
            if (ramp_st.done) begin
               state_in = ST_IDLE;
            end
         end
         ST_INDEX: begin
            if (idx_st.done) begin
               mem_re   = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration register writes.
   always_comb begin
      range_min_in     = range_min_ff;
      range_span_in    = range_span_ff;
      default_value_in = default_value_ff;
      default_color_in = default_color_ff;
      if (csr_write) begin
         unique case (csr_index)
            fcpm_pkg::CSR_RANGE_MIN:     range_min_in     = csr_data;
            fcpm_pkg::CSR_RANGE_SPAN:    range_span_in    = csr_data;
            fcpm_pkg::CSR_DEFAULT_VALUE: default_value_in = csr_data;
            fcpm_pkg::CSR_DEFAULT_COLOR: default_color_in = csr_data[CLW-1:0];
         endcase
      end
   end

   // Output register: a result waits here until the receiver takes it.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_color_in   = rsp_color_ff;
      rsp_default_in = rsp_default_ff;
      if (out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_color_in   = idx_st.is_default ? default_color_ff : rdata_ff;
         rsp_default_in = idx_st.is_default;
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_cnt_ff       <= '0;
         last_pos_ff      <= '0;
         last_color_ff    <= '0;
         have_last_ff     <= 1'b0;
         range_min_ff     <= fcpm_pkg::RANGE_MIN_RESET;
         range_span_ff    <= fcpm_pkg::RANGE_SPAN_RESET;
         default_value_ff <= fcpm_pkg::DEFAULT_VALUE_RESET;
         default_color_ff <= fcpm_pkg::DEFAULT_COLOR_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_cnt_ff       <= clr_cnt_in;
         last_pos_ff      <= last_pos_in;
         last_color_ff    <= last_color_in;
         have_last_ff     <= have_last_in;
         range_min_ff     <= range_min_in;
         range_span_ff    <= range_span_in;
         default_value_ff <= default_value_in;
         default_color_ff <= default_color_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Output payload registers.
   always_ff @(posedge clock) begin
      rsp_color_ff   <= rsp_color_in;
      rsp_default_ff <= rsp_default_in;
   end

   // Palette memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= palette_mem[mem_raddr];
      end
   end

   // Ramp engine between two control points.
   fcpm_ramp #(
      .ENTRIES (PALETTE_ENTRIES)
   ) u_ramp (
      .clock    (clock),
      .reset    (reset),
      .start    (ramp_start),
      .bottom   (last_pos_ff),
      .top      (pos_clamp),
      .color_lo (last_color_ff),
      .color_hi (point_color),
      .status   (ramp_st),
      .wr_addr  (ramp_addr),
      .wr_data  (ramp_data)
   );

   // Sample normalization and palette index.
   fcpm_index #(
      .ENTRIES     (PALETTE_ENTRIES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_index (
      .clock         (clock),
      .reset         (reset),
      .start         (idx_start),
      .sample        (req_sample_value),
      .range_min     (range_min_ff),
      .range_span    (range_span_ff),
      .default_value (default_value_ff),
      .status        (idx_st),
      .index         (idx_index)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red         = rsp_color_ff[CLW-1 -: CPW];
   assign rsp_green       = rsp_color_ff[CPW +: CPW];
   assign rsp_blue        = rsp_color_ff[0 +: CPW];
   assign rsp_was_default = rsp_default_ff;

   // Ramp writes reach the memory only while the sequencer waits on the ramp.
   a_ramp_write_in_ramp: assert property (@(posedge clock) disable iff (reset)
      ramp_st.wr_en |-> (state_ff == ST_RAMP))
      else $error("ramp engine wrote outside the ramp state");

   // The index unit reports only while a sample is in work.
   a_index_done_in_index: assert property (@(posedge clock) disable iff (reset)
      idx_st.done |-> (state_ff == ST_INDEX))
      else $error("index unit finished outside the index state");

   // Once the clearing pass is over, it does not restart without reset.
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |=> (state_ff != ST_CLEAR))
      else $error("clearing pass restarted without reset");

   // A new response is loaded only when the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("pending response overwritten");

endmodule
